### rtl/udws_pkg.sv
// Package for the UTF-8 decoder with whitespace class.
// Holds the request payload types, the lead-byte and whitespace helpers and
// the single decode step shared by the datapath. No dependencies.
package udws_pkg;

  localparam int CP_BITS  = 21;
  localparam int OUT_OFFSET_BITS = 32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } byte_item_t;

  typedef struct packed {
    logic [CP_BITS-1:0]         code_point;
    logic [OUT_OFFSET_BITS-1:0] byte_offset;
    logic [2:0]                 byte_count;
    logic                       is_space;
    logic                       run_last;
  } char_item_t;

  // Outcome of one decode step on the front of the byte buffer.
  typedef struct packed {
    logic               emit;
    logic               hold;
    logic [2:0]         used;
    logic [CP_BITS-1:0] cp;
  } step_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)        len = 3'd1;
    else if (b[7:5] == 3'b110)        len = 3'd2;
    else if (b[7:4] == 4'b1110)       len = 3'd3;
    else if (b[7:3] == 5'b11110)      len = 3'd4;
    else                              len = 3'd1;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic is_space_cp(input logic [CP_BITS-1:0] cp);
    return (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D) ||
           (cp >= 21'h2000 && cp <= 21'h200A) ||
           (cp == 21'h85) || (cp == 21'hA0) || (cp == 21'h1680) ||
           (cp == 21'h180E) || (cp == 21'h2028) || (cp == 21'h2029) ||
           (cp == 21'h202F) || (cp == 21'h205F) || (cp == 21'h3000);
  endfunction

  // One character off the front of a buffer of n bytes (0 to 4).
  function automatic step_t decode_step(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [2:0] n, input logic fin);
    step_t              s;
    logic [2:0]         len;
    logic               bad_cont;
    logic [CP_BITS-1:0] v;
    logic               bad;
    len = lead_len(b0);
    bad_cont = (n > 3'd1 && !is_cont(b1)) ||
               (n > 3'd2 && len > 3'd2 && !is_cont(b2)) ||
               (n > 3'd3 && len > 3'd3 && !is_cont(b3));
    unique case (len)
      3'd2: begin
        v   = {10'b0, b0[4:0], b1[5:0]};
        bad = v < 21'h80;
      end
      3'd3: begin
        v   = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
        bad = (v < 21'h800) || (v >= 21'hD800 && v <= 21'hDFFF);
      end
      3'd4: begin
        v   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        bad = (v < 21'h10000) || (v > 21'h10FFFF);
      end
      default: begin
        v   = '0;
        bad = 1'b1;
      end
    endcase
    s.hold = 1'b0;
    s.used = 3'd1;
    s.cp   = {13'b0, b0};
    if (len > 3'd1 && !bad_cont) begin
      if (n < len) begin
        // incomplete sequence waits for more bytes unless the text ended
        s.hold = !fin;
      end else if (!bad) begin
        s.cp   = v;
        s.used = len;
      end
    end
    s.emit = (n != 3'd0) && !s.hold;
    return s;
  endfunction

endpackage

### rtl/udws_stream_if.sv
// Valid/ready stream interface used for both channels of the decoder.
// Payload type is a parameter; types come from udws_pkg.
interface udws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/utf8_decoder_with_whitespace_class.sv
// UTF-8 decoder with whitespace class: one byte per request in, one character per request out.
// A taken byte enters the byte buffer and is decoded from there into the output register.
// Throughput: one byte per cycle while the buffer has no result left to send; the byte buffer
// yields one character per cycle to the output register, whenever that register is free.
// Reset (rst, synchronous): buffer empty, offset counter zero, no result pending.
// Depends on udws_pkg and udws_stream_if.
module utf8_decoder_with_whitespace_class #(
  parameter int OFFSET_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  udws_stream_if.sink   text,
  udws_stream_if.source chars
);

  // byte buffer: held sequence bytes plus the newest byte
  logic [7:0]             held [4];
  logic [2:0]             count;
  logic                   fin;
  logic [OFFSET_BITS-1:0] off;
  logic [OFFSET_BITS-1:0] pos;

  logic                   out_valid;
  udws_pkg::char_item_t   out_data;

  udws_pkg::step_t        step;
  udws_pkg::step_t        rem_step;
  logic [31:0]            held_vec;
  logic [31:0]            rem_vec;
  logic [7:0]             rem [4];
  logic [2:0]             rem_count;
  logic                   out_free;
  logic                   fire;
  logic                   base_idle;
  logic [7:0]             base [4];
  logic [2:0]             base_count;
  logic [OFFSET_BITS-1:0] base_off;
  logic                   accept;

  logic [7:0]             held_next [4];
  logic [2:0]             count_next;
  logic                   fin_next;
  logic [OFFSET_BITS-1:0] off_next;

  always_comb begin
    step = udws_pkg::decode_step(held[0], held[1], held[2], held[3], count, fin);
    // drop the bytes the front character used
    held_vec = {held[3], held[2], held[1], held[0]};
    rem_vec  = held_vec >> {step.used, 3'b000};
    for (int i = 0; i < 4; i++) begin
      rem[i] = rem_vec[8*i +: 8];
    end
    rem_count = count - step.used;
    rem_step  = udws_pkg::decode_step(rem[0], rem[1], rem[2], rem[3], rem_count, fin);

    out_free = !out_valid || chars.ready;
    fire     = step.emit && out_free;

    // what stays in the buffer after this cycle, before a new byte is appended
    if (fire) begin
      base       = rem;
      base_count = rem_count;
      base_off   = off + OFFSET_BITS'(step.used);
      base_idle  = (rem_count == 3'd0) || rem_step.hold;
    end else begin
      base       = held;
      base_count = count;
      base_off   = off;
      base_idle  = (count == 3'd0) || step.hold;
    end

    accept = text.valid && base_idle;

    for (int i = 0; i < 4; i++) begin
      if (accept && (3'(i) == base_count)) held_next[i] = text.data.text_byte;
      else                                 held_next[i] = base[i];
    end
    count_next = accept ? base_count + 3'd1 : base_count;
    fin_next   = accept ? text.data.text_end : fin;
    off_next   = (accept && base_count == 3'd0) ? pos : base_off;
  end

  assign text.ready  = base_idle;
  assign chars.valid = out_valid;
  assign chars.data  = out_data;

  always_ff @(posedge clk) begin
    held <= held_next;
    off  <= off_next;
    if (rst) begin
      count     <= 3'd0;
      fin       <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      fin   <= fin_next;
      if (accept) pos <= text.data.text_end ? '0 : pos + OFFSET_BITS'(1);
      if (out_free) out_valid <= step.emit;
    end
    if (fire) begin
      out_data.code_point  <= step.cp;
      out_data.byte_offset <= 32'(off);
      out_data.byte_count  <= step.used;
      out_data.is_space    <= udws_pkg::is_space_cp(step.cp);
      out_data.run_last    <= (rem_count == 3'd0) || rem_step.hold;
    end
  end

endmodule

### rtl/udws_checker.sv
// Port-level assertions for the UTF-8 decoder, attached by bind.
// Depends on udws_pkg and the top level utf8_decoder_with_whitespace_class.
module udws_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input udws_pkg::char_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_count >= 3'd1) && (out_data.byte_count <= 3'd4))
    else $error("byte count out of range");

  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_count == 3'd1 |-> out_data.code_point <= 21'hFF)
    else $error("single-byte result above one byte");

  a_multi_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_count > 3'd1 |->
      out_data.code_point >= 21'h80 && out_data.code_point <= 21'h10FFFF &&
      !(out_data.code_point >= 21'hD800 && out_data.code_point <= 21'hDFFF))
    else $error("multi-byte result not a valid scalar value");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind utf8_decoder_with_whitespace_class udws_checker u_udws_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_data  (chars.data)
);

### bench/tb_utf8_decoder_with_whitespace_class.sv
// Self-checking bench for utf8_decoder_with_whitespace_class: directed byte table, then
// random UTF-8 text checked against an in-bench decoder with random stalls on both sides.
// Depends on udws_pkg and udws_stream_if from the RTL.
module tb_utf8_decoder_with_whitespace_class;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES   = 388;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned HOLD_AFTER     = 60;

  typedef logic [udws_pkg::CP_BITS-1:0] cp_t;

  typedef struct {
    udws_pkg::byte_item_t item;
    bit                   fixed;
    udws_pkg::char_item_t want;
  } byte_row_t;

  logic clk;
  logic rst;

  udws_stream_if #(.payload_t(udws_pkg::byte_item_t)) text_if ();
  udws_stream_if #(.payload_t(udws_pkg::char_item_t)) chars_if ();

  utf8_decoder_with_whitespace_class dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .chars (chars_if)
  );

  byte_row_t            byte_rows[$];
  udws_pkg::char_item_t expected_chars[$];
  int unsigned          mismatches = 0;
  int unsigned          chars_taken = 0;
  bit                   calm = 1'b0;
  bit                   long_hold_done = 1'b0;

  // decoder state kept by the bench
  logic [7:0]  pend_bytes[3];
  int unsigned pend_count = 0;
  logic [31:0] next_pos = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned seq_len(input logic [7:0] b);
    if (b < 8'h80) return 1;
    if (b >= 8'hC0 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF7) return 4;
    return 1;
  endfunction

  function automatic bit cont_byte(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic bit space_cp(input cp_t cp);
    if (cp == 21'h20 || (cp >= 21'h09 && cp <= 21'h0D)) return 1'b1;
    if (cp >= 21'h2000 && cp <= 21'h200A) return 1'b1;
    return cp == 21'h85 || cp == 21'hA0 || cp == 21'h1680 || cp == 21'h180E ||
           cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F ||
           cp == 21'h3000;
  endfunction

  // Decode one accepted byte; results go to expected_chars when keep is set.
  task automatic decode_byte(input logic [7:0] b, input logic fin, input bit keep);
    logic [7:0]           win[$];
    udws_pkg::char_item_t out_q[$];
    udws_pkg::char_item_t ch;
    logic [31:0]          off;
    cp_t                  v;
    cp_t                  cp;
    int unsigned          len;
    int unsigned          k;
    int unsigned          used;
    bit                   hold;
    bit                   bad;
    for (int i = 0; i < pend_count; i++) win.insert(win.size(), pend_bytes[i]);
    win.insert(win.size(), b);
    off = next_pos - 32'(win.size() - 1);
    next_pos = next_pos + 32'd1;
    while (win.size() > 0) begin
      len  = seq_len(win[0]);
      used = 1;
      cp   = {13'b0, win[0]};
      hold = 1'b0;
      if (len > 1) begin
        k = 1;
        while (k < win.size() && k < len && cont_byte(win[k])) k++;
        if (k < win.size() && k < len) begin
          // a non-continuation byte broke the sequence: lead alone
        end else if (win.size() < len) begin
          hold = !fin;
        end else begin
          v = {13'b0, win[0] & (8'h7F >> len)};
          for (int j = 1; j < len; j++) v = {v[14:0], win[j][5:0]};
          case (len)
            2:       bad = v < 21'h80;
            3:       bad = v < 21'h800 || (v >= 21'hD800 && v <= 21'hDFFF);
            default: bad = v < 21'h10000 || v > 21'h10FFFF;
          endcase
          if (!bad) begin
            cp   = v;
            used = len;
          end
        end
      end
      if (hold) break;
      ch.code_point  = cp;
      ch.byte_offset = off;
      ch.byte_count  = 3'(used);
      ch.is_space    = space_cp(cp);
      ch.run_last    = 1'b0;
      out_q.insert(out_q.size(), ch);
      off = off + 32'(used);
      repeat (used) void'(win.pop_front());
    end
    if (out_q.size() > 0) begin
      ch = out_q[out_q.size()-1];
      ch.run_last = 1'b1;
      out_q[out_q.size()-1] = ch;
    end
    if (keep) foreach (out_q[i]) expected_chars.insert(expected_chars.size(), out_q[i]);
    if (fin) begin
      win = {};
      next_pos = '0;
    end
    pend_count = win.size();
    for (int i = 0; i < pend_count; i++) pend_bytes[i] = win[i];
  endtask

  task automatic add_row(input logic [7:0] b, input logic fin);
    byte_row_t r;
    r.item.text_byte = b;
    r.item.text_end  = fin;
    r.fixed          = 1'b0;
    r.want           = '0;
    byte_rows.insert(byte_rows.size(), r);
  endtask

  // Row whose single result is known outright: one byte, last of its request.
  task automatic add_fixed(input logic [7:0] b, input logic fin, input cp_t cp,
                           input logic [31:0] off, input logic sp);
    byte_row_t r;
    r.item.text_byte    = b;
    r.item.text_end     = fin;
    r.fixed             = 1'b1;
    r.want.code_point   = cp;
    r.want.byte_offset  = off;
    r.want.byte_count   = 3'd1;
    r.want.is_space     = sp;
    r.want.run_last     = 1'b1;
    byte_rows.insert(byte_rows.size(), r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    add_row(b, $urandom_range(0, 23) == 0);
  endtask

  // Encode cp in len bytes (overlong and out-of-range values allowed), keep the first n.
  task automatic push_seq(input cp_t cp, input int unsigned len, input int unsigned n);
    logic [7:0] enc[4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < n; i++) push_byte(enc[i]);
  endtask

  function automatic cp_t legal_cp(input int unsigned len);
    cp_t cp;
    case (len)
      1: cp = cp_t'($urandom_range(0, 'h7F));
      2: cp = cp_t'($urandom_range('h80, 'h7FF));
      3: begin
        cp = cp_t'($urandom_range('h800, 'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
      end
      default: cp = cp_t'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // whitespace code points and a few near misses
  function automatic cp_t space_pick(input int unsigned i);
    case (i)
      0:  return 21'h20;
      1:  return 21'h09;
      2:  return 21'h0A;
      3:  return 21'h0B;
      4:  return 21'h0C;
      5:  return 21'h0D;
      6:  return 21'h85;
      7:  return 21'hA0;
      8:  return 21'h1680;
      9:  return 21'h180E;
      10: return 21'h2000;
      11: return 21'h2005;
      12: return 21'h200A;
      13: return 21'h2028;
      14: return 21'h2029;
      15: return 21'h202F;
      16: return 21'h205F;
      17: return 21'h3000;
      18: return 21'h08;
      19: return 21'h0E;
      default: return 21'h200B;
    endcase
  endfunction

  function automatic int unsigned enc_len(input cp_t cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Output side: compare every accepted character with the oldest expectation.
  always @(posedge clk) begin
    udws_pkg::char_item_t got;
    udws_pkg::char_item_t want;
    if (!rst && chars_if.valid && chars_if.ready) begin
      got = chars_if.data;
      chars_taken++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: code_point %0h byte_offset %0d",
               got.code_point, got.byte_offset);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (got.code_point !== want.code_point) begin
          $error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
          mismatches++;
        end
        if (got.byte_offset !== want.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
          mismatches++;
        end
        if (got.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
          mismatches++;
        end
        if (got.is_space !== want.is_space) begin
          $error("is_space: expected %0b, got %0b", want.is_space, got.is_space);
          mismatches++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the decoder backs up into its input.
  initial begin
    chars_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && chars_taken >= HOLD_AFTER) begin
        chars_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        chars_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      chars_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog: too long without any request moving on either side.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (text_if.valid && text_if.ready) || (chars_if.valid && chars_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sender: directed table, then random text.
  initial begin
    byte_row_t          row;
    int unsigned        directed_n;
    int unsigned        pause_at;
    int unsigned        calm_from;
    int unsigned        pick;
    int unsigned        len;
    cp_t                cp;

    rst            <= 1'b1;
    text_if.valid  <= 1'b0;
    text_if.data   <= '0;

    // after reset, extremes and bad leads, then a text end
    add_fixed(8'h00, 1'b0, 21'h00, 32'd0, 1'b0);
    add_fixed(8'h7F, 1'b0, 21'h7F, 32'd1, 1'b0);
    add_fixed(8'hFF, 1'b0, 21'hFF, 32'd2, 1'b0);
    add_fixed(8'h80, 1'b0, 21'h80, 32'd3, 1'b0);
    add_fixed(8'h20, 1'b1, 21'h20, 32'd4, 1'b1);
    // stray bytes 0x85 and 0xA0 still count as whitespace
    add_fixed(8'h85, 1'b0, 21'h85, 32'd0, 1'b1);
    add_fixed(8'hA0, 1'b0, 21'hA0, 32'd1, 1'b1);
    add_row(8'hC2, 1'b0); add_row(8'hA0, 1'b0);
    add_row(8'hE2, 1'b0); add_row(8'h80, 1'b0); add_row(8'hA8, 1'b0);
    add_row(8'hF4, 1'b0); add_row(8'h8F, 1'b0); add_row(8'hBF, 1'b0); add_row(8'hBF, 1'b0);
    // overlong two-byte form
    add_row(8'hC0, 1'b0); add_row(8'h80, 1'b0);
    // surrogate
    add_row(8'hED, 1'b0); add_row(8'hA0, 1'b0); add_row(8'h80, 1'b0);
    // above the code space
    add_row(8'hF4, 1'b0); add_row(8'h90, 1'b0); add_row(8'h80, 1'b0); add_row(8'h80, 1'b0);
    // continuation missing, held bytes flushed one by one
    add_row(8'hE2, 1'b0); add_row(8'h80, 1'b0); add_row(8'h41, 1'b0);
    // text ends mid sequence
    add_row(8'hE3, 1'b0); add_row(8'h81, 1'b1);
    directed_n = byte_rows.size();

    while (byte_rows.size() < directed_n + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (pick < 55) begin
        push_seq(legal_cp(len), len, len);
      end else if (pick < 65) begin
        cp = space_pick($urandom_range(0, 20));
        push_seq(cp, enc_len(cp), enc_len(cp));
      end else if (pick < 75) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 83) begin
        len = $urandom_range(2, 4);
        push_seq(legal_cp(len), len, $urandom_range(1, len - 1));
      end else if (pick < 89) begin
        len = $urandom_range(2, 4);
        push_seq(legal_cp(len - 1), len, len);
      end else if (pick < 94) begin
        push_seq(cp_t'($urandom_range('hD800, 'hDFFF)), 3, 3);
      end else begin
        push_seq(cp_t'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
      end
    end
    pause_at  = directed_n + 250;
    calm_from = byte_rows.size() - 60;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int unsigned idx = 0; idx < byte_rows.size(); idx++) begin
      row = byte_rows[idx];
      if (idx >= calm_from) calm = 1'b1;
      if (idx == pause_at) begin
        // let the decoder drain completely before going on
        text_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
      end else if (!calm && (idx / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
        text_if.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      text_if.valid <= 1'b1;
      text_if.data  <= row.item;
      do @(posedge clk); while (!text_if.ready);
      decode_byte(row.item.text_byte, row.item.text_end, !row.fixed);
      if (row.fixed) expected_chars.insert(expected_chars.size(), row.want);
    end
    text_if.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
